// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the solver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked only out of reset.
`define QRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qrs assertion failed");
// Checked at every edge, reset included.
`define QRS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("qrs assertion failed");
`else
`define QRS_ASSERT(lbl, clk, rst_n, prop)
`define QRS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/core/qrs_pkg.sv -----
// Types and constants of the quadratic root solver.
package qrs_pkg;
  localparam int COEF_W = 16;
  localparam int ROOT_W = 34;
  localparam int RAD_W  = 34;
  localparam int DEN_W  = COEF_W + 1;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_TWO   = 2'd2,
    KIND_DEGEN = 2'd3
  } root_kind_t;
endpackage

// ----- rtl/core/qrs_disc.sv -----
// Discriminant front end: input register, products, discriminant and kind.
module qrs_disc (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [qrs_pkg::COEF_W-1:0] in_a,
  input  logic signed [qrs_pkg::COEF_W-1:0] in_b,
  input  logic signed [qrs_pkg::COEF_W-1:0] in_c,
  output logic                              out_valid,
  output qrs_pkg::root_kind_t               out_kind,
  output logic signed [qrs_pkg::COEF_W-1:0] out_a,
  output logic signed [qrs_pkg::COEF_W-1:0] out_b,
  output logic [qrs_pkg::RAD_W-1:0]         out_rad
);
  import qrs_pkg::*;

  logic                     v0_r, v1_r, v2_r;
  logic signed [COEF_W-1:0] a0_r, b0_r, c0_r;
  logic signed [COEF_W-1:0] a1_r, b1_r;
  logic signed [31:0]       bb_r, ac_r;
  logic signed [34:0]       disc;
  root_kind_t               kind_nxt, kind_r;
  logic signed [COEF_W-1:0] a2_r, b2_r;
  logic [RAD_W-1:0]         rad_r;

  // b*b - 4ac, exact in 35 bits
  assign disc = {{3{bb_r[31]}}, bb_r} - {ac_r[31], ac_r, 2'b00};

  always_comb begin
    if (a1_r == '0) begin
      kind_nxt = KIND_DEGEN;
    end else if (disc[34]) begin
      kind_nxt = KIND_NONE;
    end else if (disc == '0) begin
      kind_nxt = KIND_ONE;
    end else begin
      kind_nxt = KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
    a0_r   <= in_a;
    b0_r   <= in_b;
    c0_r   <= in_c;
    bb_r   <= 32'(b0_r) * 32'(b0_r);
    ac_r   <= 32'(a0_r) * 32'(c0_r);
    a1_r   <= a0_r;
    b1_r   <= b0_r;
    kind_r <= kind_nxt;
    a2_r   <= a1_r;
    b2_r   <= b1_r;
    rad_r  <= disc[RAD_W-1:0];
  end

  assign out_valid = v2_r;
  assign out_kind  = kind_r;
  assign out_a     = a2_r;
  assign out_b     = b2_r;
  assign out_rad   = rad_r;
endmodule

// ----- rtl/core/qrs_sqrt.sv -----
// Pipelined square root, one result bit per stage, with fraction bits.
module qrs_sqrt #(
  parameter int FRAC_BITS = 16,
  parameter int TAG_W     = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [qrs_pkg::RAD_W-1:0] in_rad,
  input  logic [TAG_W-1:0]          in_tag,
  output logic                      out_valid,
  output logic [FRAC_BITS+16:0]     out_root,
  output logic [TAG_W-1:0]          out_tag
);
  import qrs_pkg::*;

  localparam int NS  = FRAC_BITS + 17;
  localparam int RTW = NS;
  localparam int RW  = RTW + 3;

  logic             v_a   [NS+1];
  logic [RW-1:0]    rem_a [NS+1];
  logic [RTW-1:0]   root_a[NS+1];
  logic [RAD_W-1:0] dsh_a [NS+1];
  logic [TAG_W-1:0] tag_a [NS+1];

  assign v_a[0]    = in_valid;
  assign rem_a[0]  = '0;
  assign root_a[0] = '0;
  assign dsh_a[0]  = in_rad;
  assign tag_a[0]  = in_tag;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RW-1:0] remsh;
    logic [RW-1:0] trial;
    logic          ge;

    // bring down next bit pair; zeros once the radicand is used up
    assign remsh = {rem_a[k][RW-3:0], dsh_a[k][RAD_W-1 -: 2]};
    assign trial = {1'b0, root_a[k], 2'b01};
    assign ge    = (remsh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_a[k+1] <= 1'b0;
      end else begin
        v_a[k+1] <= v_a[k];
      end
      rem_a[k+1]  <= ge ? (remsh - trial) : remsh;
      root_a[k+1] <= {root_a[k][RTW-2:0], ge};
      dsh_a[k+1]  <= {dsh_a[k][RAD_W-3:0], 2'b00};
      tag_a[k+1]  <= tag_a[k];
    end
  end

  assign out_valid = v_a[NS];
  assign out_root  = root_a[NS];
  assign out_tag   = tag_a[NS];
endmodule

// ----- rtl/core/qrs_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
module qrs_div #(
  parameter int NW    = 34,
  parameter int TAG_W = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [NW-1:0]             in_num,
  input  logic [qrs_pkg::DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0]          in_tag,
  output logic                      out_valid,
  output logic [NW-1:0]             out_quo,
  output logic [TAG_W-1:0]          out_tag
);
  import qrs_pkg::*;

  logic             v_a  [NW+1];
  logic [DEN_W:0]   rem_a[NW+1];
  logic [NW-1:0]    num_a[NW+1];
  logic [NW-1:0]    quo_a[NW+1];
  logic [DEN_W-1:0] den_a[NW+1];
  logic [TAG_W-1:0] tag_a[NW+1];

  assign v_a[0]   = in_valid;
  assign rem_a[0] = '0;
  assign num_a[0] = in_num;
  assign quo_a[0] = '0;
  assign den_a[0] = in_den;
  assign tag_a[0] = in_tag;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DEN_W:0] remsh;
    logic [DEN_W:0] dx;
    logic           ge;

    assign remsh = {rem_a[k][DEN_W-1:0], num_a[k][NW-1]};
    assign dx    = {1'b0, den_a[k]};
    assign ge    = (remsh >= dx);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_a[k+1] <= 1'b0;
      end else begin
        v_a[k+1] <= v_a[k];
      end
      rem_a[k+1] <= ge ? (remsh - dx) : remsh;
      num_a[k+1] <= {num_a[k][NW-2:0], 1'b0};
      quo_a[k+1] <= {quo_a[k][NW-2:0], ge};
      den_a[k+1] <= den_a[k];
      tag_a[k+1] <= tag_a[k];
    end
  end

  assign out_valid = v_a[NW];
  assign out_quo   = quo_a[NW];
  assign out_tag   = tag_a[NW];
endmodule

// ----- rtl/core/quadratic_root_solver.sv -----
// Top level of the fixed-point quadratic root solver.
// Takes a*x^2 + b*x + c as three signed 16-bit coefficients, one beat per
// cycle, and returns one result beat per item, in order, on out_valid. Each
// item is accepted when start is high; busy is tied low because the pipeline
// never stalls, and the receiver must take every result in the cycle it is
// shown. The pipeline holds, in order, the input register, the register of
// the two 16x16 products and the discriminant register, FRAC_BITS + 17
// square-root stages (one root bit each), one numerator stage, FRAC_BITS + 18
// divider stages (one quotient bit each) and the output register.
// root_kind: 0 no real roots, 1 one root, 2 two roots,
// 3 degenerate (a = 0). Roots are signed with FRAC_BITS fraction bits,
// truncated toward zero, and read zero for kinds 0 and 3.
`include "assert_macros.svh"
module quadratic_root_solver #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [qrs_pkg::COEF_W-1:0] in_coef_a,
  input  logic signed [qrs_pkg::COEF_W-1:0] in_coef_b,
  input  logic signed [qrs_pkg::COEF_W-1:0] in_coef_c,
  output logic                              out_valid,
  output logic [1:0]                        out_root_kind,
  output logic signed [qrs_pkg::ROOT_W-1:0] out_root_plus,
  output logic signed [qrs_pkg::ROOT_W-1:0] out_root_minus
);
  import qrs_pkg::*;

  localparam int RTW   = FRAC_BITS + 17;      // square-root width
  localparam int NSW   = FRAC_BITS + 19;      // signed numerator width
  localparam int NW    = NSW - 1;             // numerator magnitude / quotient
  localparam int XW    = (NW + 1 > ROOT_W) ? NW + 1 : ROOT_W;
  localparam int STAG  = 2 + 2 * COEF_W;      // kind, a, b

  // never back-pressures
  assign busy = 1'b0;

  // discriminant front end
  logic                     d_valid;
  root_kind_t               d_kind;
  logic signed [COEF_W-1:0] d_a, d_b;
  logic [RAD_W-1:0]         d_rad;

  qrs_disc u_disc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_a      (in_coef_a),
    .in_b      (in_coef_b),
    .in_c      (in_coef_c),
    .out_valid (d_valid),
    .out_kind  (d_kind),
    .out_a     (d_a),
    .out_b     (d_b),
    .out_rad   (d_rad)
  );

  // square root, floored to FRAC_BITS fraction bits
  logic             s_valid;
  logic [RTW-1:0]   s_root;
  logic [STAG-1:0]  s_tag;

  qrs_sqrt #(.FRAC_BITS(FRAC_BITS), .TAG_W(STAG)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_rad    (d_rad),
    .in_tag    ({d_kind, d_a, d_b}),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_tag   (s_tag)
  );

  // numerator stage: -b*2^F +/- s, split into sign and magnitude
  root_kind_t               s_kind;
  logic signed [COEF_W-1:0] s_a, s_b;
  logic [COEF_W-1:0]        a_mag;
  logic signed [NSW-1:0]    bx, nb, sx, np, nm;
  logic signed [NSW-1:0]    np_abs, nm_abs;

  assign s_kind = root_kind_t'(s_tag[STAG-1 -: 2]);
  assign s_a    = s_tag[2*COEF_W-1 -: COEF_W];
  assign s_b    = s_tag[COEF_W-1:0];
  assign a_mag  = s_a[COEF_W-1] ? COEF_W'(-s_a) : COEF_W'(s_a);
  assign bx     = {{(NSW-COEF_W){s_b[COEF_W-1]}}, s_b};
  assign nb     = -(bx <<< FRAC_BITS);
  assign sx     = {{(NSW-RTW){1'b0}}, s_root};
  assign np     = nb + sx;
  assign nm     = nb - sx;
  assign np_abs = np[NSW-1] ? -np : np;
  assign nm_abs = nm[NSW-1] ? -nm : nm;

  logic             n_valid_r;
  root_kind_t       n_kind_r;
  logic [NW-1:0]    n_magp_r, n_magm_r;
  logic [DEN_W-1:0] n_den_r;
  logic             n_negp_r, n_negm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_valid_r <= 1'b0;
    end else begin
      n_valid_r <= s_valid;
    end
    n_kind_r <= s_kind;
    n_magp_r <= np_abs[NW-1:0];
    n_magm_r <= nm_abs[NW-1:0];
    n_den_r  <= {a_mag, 1'b0};               // |2a|
    n_negp_r <= np[NSW-1] ^ s_a[COEF_W-1];
    n_negm_r <= nm[NSW-1] ^ s_a[COEF_W-1];
  end

  // two dividers side by side; kind rides with the plus root
  logic          qp_valid, qm_valid;
  logic [NW-1:0] qp_quo, qm_quo;
  logic [2:0]    qp_tag;
  logic          qm_tag;

  qrs_div #(.NW(NW), .TAG_W(3)) u_div_plus (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n_valid_r),
    .in_num    (n_magp_r),
    .in_den    (n_den_r),
    .in_tag    ({n_kind_r, n_negp_r}),
    .out_valid (qp_valid),
    .out_quo   (qp_quo),
    .out_tag   (qp_tag)
  );

  qrs_div #(.NW(NW), .TAG_W(1)) u_div_minus (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n_valid_r),
    .in_num    (n_magm_r),
    .in_den    (n_den_r),
    .in_tag    (n_negm_r),
    .out_valid (qm_valid),
    .out_quo   (qm_quo),
    .out_tag   (qm_tag)
  );

  // sign restore, wrap to the result width, zero where there is no root
  root_kind_t        q_kind;
  logic              has_root;
  logic [XW-1:0]     xp, xm, sp, sm;

  assign q_kind   = root_kind_t'(qp_tag[2:1]);
  assign has_root = (q_kind == KIND_ONE) || (q_kind == KIND_TWO);
  assign xp       = {{(XW-NW){1'b0}}, qp_quo};
  assign xm       = {{(XW-NW){1'b0}}, qm_quo};
  assign sp       = qp_tag[0] ? -xp : xp;
  assign sm       = qm_tag ? -xm : xm;

  logic              o_valid_r;
  logic [1:0]        o_kind_r;
  logic [ROOT_W-1:0] o_plus_r, o_minus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else begin
      o_valid_r <= qp_valid;
    end
    o_kind_r  <= q_kind;
    o_plus_r  <= has_root ? sp[ROOT_W-1:0] : '0;
    o_minus_r <= has_root ? sm[ROOT_W-1:0] : '0;
  end

  assign out_valid      = o_valid_r;
  assign out_root_kind  = o_kind_r;
  assign out_root_plus  = o_plus_r;
  assign out_root_minus = o_minus_r;

  // the two divider lanes stay in lockstep
  `QRS_ASSERT(a_lanes_lockstep, clk, rst_n, qp_valid == qm_valid)
  // no root, no value
  `QRS_ASSERT(a_zero_when_none, clk, rst_n, (out_valid && (out_root_kind == KIND_NONE || out_root_kind == KIND_DEGEN)) |-> (out_root_plus == '0 && out_root_minus == '0))
  // a double root gives the same value on both outputs
  `QRS_ASSERT(a_one_root_equal, clk, rst_n, (out_valid && out_root_kind == KIND_ONE) |-> (out_root_plus == out_root_minus))
  // the pipeline never holds the sender off
  `QRS_ASSERT_ALWAYS(a_never_busy, clk, !busy)
endmodule

// ----- bench/quadratic_root_solver_tb.sv -----
// Self-checking bench for the quadratic root solver: directed and random coefficients.
`timescale 1ns / 1ps
module quadratic_root_solver_tb;
  import qrs_pkg::*;

  localparam int FRAC     = 16;
  localparam int LATENCY  = 2 * FRAC + 40;
  localparam int WD_LIMIT = 4000;   // idle cycles; far above latency plus the longest gap
  localparam int N_RANDOM = 880;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coefs_t;

  typedef struct packed {
    root_kind_t               kind;
    logic signed [ROOT_W-1:0] plus;
    logic signed [ROOT_W-1:0] minus;
  } roots_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [COEF_W-1:0] in_coef_a, in_coef_b, in_coef_c;
  logic                     out_valid;
  logic [1:0]               out_root_kind;
  logic signed [ROOT_W-1:0] out_root_plus, out_root_minus;

  coefs_t pending_coefs[$];   // beats not yet driven
  roots_t expected_roots[$];  // predicted results, oldest first
  int     n_mismatch = 0;
  int     idle_cycles = 0;
  int     beats_loaded = 0;
  int     gap_left = 0;
  bit     burst_mode = 0;     // stretch with no idling on the input side
  bit     stim_done = 0;

  quadratic_root_solver #(.FRAC_BITS(FRAC)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_coef_a      (in_coef_a),
    .in_coef_b      (in_coef_b),
    .in_coef_c      (in_coef_c),
    .out_valid      (out_valid),
    .out_root_kind  (out_root_kind),
    .out_root_plus  (out_root_plus),
    .out_root_minus (out_root_minus)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // floor(sqrt(d) * 2^FRAC), restoring method, one root bit per step
  function automatic longint unsigned sqrt_scaled(longint unsigned d);
    longint unsigned rem, root, pair, trial;
    rem = 0;
    root = 0;
    for (int i = 16 + FRAC; i >= 0; i--) begin
      pair = (i >= FRAC) ? ((d >> (2 * (i - FRAC))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic roots_t solve_roots(coefs_t q);
    roots_t r;
    longint a, b, c, disc, nb, den, s, rp, rm;
    a = q.a;
    b = q.b;
    c = q.c;
    rp = 0;
    rm = 0;
    if (a == 0) begin
      r.kind = KIND_DEGEN;
    end else begin
      disc = b * b - 4 * a * c;
      nb   = -b * (64'sd1 <<< FRAC);
      den  = 2 * a;
      if (disc < 0) begin
        r.kind = KIND_NONE;
      end else if (disc == 0) begin
        r.kind = KIND_ONE;
        rp = nb / den;    // SV division truncates toward zero
        rm = rp;
      end else begin
        s = longint'(sqrt_scaled(longint'(disc)));
        r.kind = KIND_TWO;
        rp = (nb + s) / den;
        rm = (nb - s) / den;
      end
    end
    r.plus  = rp[ROOT_W-1:0];
    r.minus = rm[ROOT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    n_mismatch++;
  endtask

  function automatic int pick_gap();
    if (burst_mode || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Driver: holds start until the beat is taken, then loads the next one
  // after a random gap. One NBA on start per edge.
  always @(posedge clk) begin
    bit     accepted;
    bit     nxt_start;
    coefs_t q;
    if (!rst_n) begin
      start     <= 1'b0;
      in_coef_a <= '0;
      in_coef_b <= '0;
      in_coef_c <= '0;
    end else begin
      accepted  = start && !busy;
      nxt_start = start && !accepted;
      if (accepted) begin
        expected_roots.push_back(solve_roots({in_coef_a, in_coef_b, in_coef_c}));
        gap_left = pick_gap();
        if ($urandom_range(0, 99) == 0) burst_mode = !burst_mode;
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_coefs.size() != 0 &&
                     !(beats_loaded == 450 && expected_roots.size() != 0)) begin
          // half way through, the pipeline is drained before the next beat
          q = pending_coefs.pop_front();
          in_coef_a <= q.a;
          in_coef_b <= q.b;
          in_coef_c <= q.c;
          beats_loaded++;
          nxt_start = 1'b1;
        end
      end
      start <= nxt_start;
    end
  end

  // Monitor: every strobed result is compared with the oldest prediction.
  always @(posedge clk) begin
    roots_t want;
    if (rst_n && out_valid) begin
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected beat, kind", out_root_kind, 0);
      end else begin
        want = expected_roots.pop_front();
        if (out_root_kind !== want.kind)
          report_mismatch("root_kind", out_root_kind, want.kind);
        if (out_root_plus !== want.plus)
          report_mismatch("root_plus", out_root_plus, want.plus);
        if (out_root_minus !== want.minus)
          report_mismatch("root_minus", out_root_minus, want.minus);
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic add_item(int a, int b, int c);
    pending_coefs.push_back({16'(a), 16'(b), 16'(c)});
  endtask

  initial begin
    int k, sel;
    rst_n = 1'b0;
    // directed: degenerate, no roots, one root, two roots, extremes
    add_item(0, 0, 0);
    add_item(0, 32767, -32768);
    add_item(0, -32768, 32767);
    add_item(1, 0, 1);                  // no real roots
    add_item(-32768, 0, -32768);
    add_item(32767, 0, 32767);
    add_item(1, 2, 1);                  // one root
    add_item(-1, 2, -1);
    add_item(3, 0, 0);
    add_item(-32768, 0, 0);
    add_item(1, -32768, 0);             // widest roots
    add_item(-1, -32768, 0);
    add_item(1, 32767, 0);
    add_item(-32768, -32768, 32767);    // largest discriminant
    add_item(32767, -32768, -32768);
    add_item(32767, 32767, -32768);
    add_item(-32768, 32767, 32767);
    add_item(1, 0, -2);                 // irrational root
    add_item(2, -3, 1);
    add_item(-3, 5, 7);
    add_item(1, -1, -1);
    add_item(32767, 1, 0);
    repeat (N_RANDOM) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        add_item(0, $urandom, $urandom);
      end else if (sel == 1) begin
        // perfect square: b = 2k, a = c = k
        k = $urandom_range(1, 16383);
        if ($urandom_range(0, 1)) k = -k;
        add_item(k, 2 * k, k);
      end else if (sel == 2) begin
        // small coefficients: all kinds likely
        add_item($urandom_range(0, 15) - 8, $urandom_range(0, 31) - 16,
                 $urandom_range(0, 15) - 8);
      end else begin
        add_item($urandom, $urandom, $urandom);
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_coefs.size() != 0) @(posedge clk);
    @(posedge clk);
    while (start || expected_roots.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
